[rtl/mqg_pkg.sv]
// shared types, constants and quadrature step tables for the step quadrature generator
// no dependencies; used by every other file of the block
package mqg_pkg;

    localparam int MQG_MAX_CH      = 8;
    localparam int MQG_CHANNELS    = 8;
    localparam int MQG_CYCLE_BITS  = 12;
    localparam int MQG_COUNT_W     = 13;
    localparam int MQG_CFG_W       = 12;
    localparam int MQG_POS_W       = 32;
    localparam int MQG_SEL_W       = 3;
    localparam int MQG_PORT_W      = 8;

    localparam logic [MQG_CFG_W-1:0] MQG_PATH_CYCLES_RST = 12'd400;

    localparam logic MQG_OP_TICK = 1'b0;
    localparam logic MQG_OP_LOAD = 1'b1;

    typedef struct packed {
        logic load;
        logic tick;
    } t_lane_ctl;

    typedef struct packed {
        logic                 step;
        logic [1:0]           code;
        logic [MQG_POS_W-1:0] position;
    } t_lane_out;

    // gray sequence 00,10,11,01 going forward
    function automatic logic [1:0] quad_fwd(input logic [1:0] code);
        logic [1:0] r;
        case (code)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            2'd2:    r = 2'd3;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] quad_back(input logic [1:0] code);
        logic [1:0] r;
        case (code)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd3;
            2'd2:    r = 2'd0;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

[rtl/mqg_lane.sv]
// one interpolation channel: magnitude, direction, spread accumulator,
// quadrature code and position counter; depends on mqg_pkg
module mqg_lane import mqg_pkg::*; #(
    parameter int CYCLE_BITS = MQG_CYCLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  logic [CYCLE_BITS-1:0]         i_period,
    input  logic signed [MQG_COUNT_W-1:0] i_count,
    output t_lane_out                     o_lane
);

    localparam int MW = (CYCLE_BITS > MQG_COUNT_W) ? CYCLE_BITS : MQG_COUNT_W;

    logic [CYCLE_BITS-1:0] r_mag, n_mag;
    logic                  r_dir, n_dir;
    logic [CYCLE_BITS-1:0] r_acc, n_acc;
    logic [1:0]            r_code, n_code;
    logic [MQG_POS_W-1:0]  r_pos, n_pos;

    logic                   w_neg;
    logic [MQG_COUNT_W-1:0] w_raw_mag;
    logic [CYCLE_BITS-1:0]  w_mag_c;
    logic                   w_step;

    always_comb begin
        w_neg     = i_count[MQG_COUNT_W-1];
        w_raw_mag = w_neg ? (MQG_COUNT_W'(0) - MQG_COUNT_W'(i_count)) : MQG_COUNT_W'(i_count);
        // clamp to the segment length
        if (MW'(w_raw_mag) > MW'(i_period)) begin
            w_mag_c = i_period;
        end else begin
            w_mag_c = CYCLE_BITS'(w_raw_mag);
        end
        w_step = i_ctl.tick && (r_mag != '0) && (r_acc < r_mag);
    end

    always_comb begin
        n_mag  = r_mag;
        n_dir  = r_dir;
        n_acc  = r_acc;
        n_code = r_code;
        n_pos  = r_pos;
        if (i_ctl.load) begin
            n_mag = w_mag_c;
            n_dir = w_neg && (w_mag_c != '0);
            // (P-1)*n mod P for the first tick
            if ((w_mag_c == '0) || (w_mag_c == i_period)) begin
                n_acc = '0;
            end else begin
                n_acc = i_period - w_mag_c;
            end
        end else if (i_ctl.tick) begin
            if (r_acc >= r_mag) begin
                n_acc = r_acc - r_mag;
            end else begin
                n_acc = r_acc + i_period - r_mag;
            end
            if (w_step) begin
                if (r_dir) begin
                    n_code = quad_back(r_code);
                    n_pos  = r_pos - MQG_POS_W'(1);
                end else begin
                    n_code = quad_fwd(r_code);
                    n_pos  = r_pos + MQG_POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag  <= '0;
            r_dir  <= 1'b0;
            r_acc  <= '0;
            r_code <= '0;
            r_pos  <= '0;
        end else begin
            r_mag  <= n_mag;
            r_dir  <= n_dir;
            r_acc  <= n_acc;
            r_code <= n_code;
            r_pos  <= n_pos;
        end
    end

    always_comb begin
        o_lane.step     = w_step;
        o_lane.code     = n_code;
        o_lane.position = n_pos;
    end

endmodule

[rtl/mqg_merge.sv]
// merging stage: packs lane codes into the two port bytes, builds the step
// mask, selects the reported position and holds the result register; depends on mqg_pkg
module mqg_merge import mqg_pkg::*; #(
    parameter int CHANNELS = MQG_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic                  i_take,
    input  t_lane_out             i_lane [MQG_MAX_CH],
    input  logic [MQG_SEL_W-1:0]  i_sel,
    input  logic                  i_done,
    input  logic                  i_active,
    output logic                  o_valid,
    output logic [MQG_PORT_W-1:0] o_motor_port,
    output logic [MQG_PORT_W-1:0] o_image_port,
    output logic [MQG_PORT_W-1:0] o_step_mask,
    output logic                  o_segment_done,
    output logic                  o_active,
    output logic [MQG_POS_W-1:0]  o_position
);

    logic                  r_valid, n_valid;
    logic [MQG_PORT_W-1:0] r_motor, r_image, r_mask;
    logic                  r_done, r_active;
    logic [MQG_POS_W-1:0]  r_pos;

    logic [MQG_PORT_W-1:0] w_motor, w_image, w_mask;
    logic [MQG_POS_W-1:0]  w_pos;

    always_comb begin
        w_motor = '0;
        w_image = '0;
        w_mask  = '0;
        for (int i = 0; i < 4; i++) begin
            w_motor[7-2*i -: 2] = i_lane[i].code;
            w_image[7-2*i -: 2] = i_lane[i+4].code;
        end
        for (int i = 0; i < MQG_MAX_CH; i++) begin
            w_mask[i] = i_lane[i].step;
        end
        if ({1'b0, i_sel} < 4'(CHANNELS)) begin
            w_pos = i_lane[i_sel].position;
        end else begin
            w_pos = '0;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_motor  <= w_motor;
            r_image  <= w_image;
            r_mask   <= w_mask;
            r_done   <= i_done;
            r_active <= i_active;
            r_pos    <= w_pos;
        end
    end

    assign o_valid        = r_valid;
    assign o_motor_port   = r_motor;
    assign o_image_port   = r_image;
    assign o_step_mask    = r_mask;
    assign o_segment_done = r_done;
    assign o_active       = r_active;
    assign o_position     = r_pos;

endmodule

[rtl/multi_axis_step_quadrature_generator_top.sv]
// top level of the step quadrature generator: handshake, period register,
// segment cycle counter, channel lanes and merge stage; depends on mqg_pkg, mqg_lane, mqg_merge
//
// channel   | direction | handshake         | payload
// request   | in        | i_valid / o_stall | i_opcode, i_count_0..7, i_report_channel
// result    | out       | o_valid / i_stall | o_motor_port, o_image_port, o_step_mask,
//           |           |                   | o_segment_done, o_active, o_position
// config    | in        | i_cfg_valid /     | i_cfg_data (path_cycles)
//           |           | o_cfg_ready       |
//
// one request per cycle while o_stall is low; every lane does one accumulator add and compare per tick,
// and the result shows up in the output register in the cycle after acceptance.
// synchronous active-low reset clears all channel state and the result valid flag,
// and sets path_cycles to 400.
// o_stall is high only while a result is held and i_stall is high; a new request
// is taken in the same cycle that the held result is taken.
module multi_axis_step_quadrature_generator_top import mqg_pkg::*; #(
    parameter int CHANNELS   = MQG_CHANNELS,
    parameter int CYCLE_BITS = MQG_CYCLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic signed [MQG_COUNT_W-1:0] i_count_0,
    input  logic signed [MQG_COUNT_W-1:0] i_count_1,
    input  logic signed [MQG_COUNT_W-1:0] i_count_2,
    input  logic signed [MQG_COUNT_W-1:0] i_count_3,
    input  logic signed [MQG_COUNT_W-1:0] i_count_4,
    input  logic signed [MQG_COUNT_W-1:0] i_count_5,
    input  logic signed [MQG_COUNT_W-1:0] i_count_6,
    input  logic signed [MQG_COUNT_W-1:0] i_count_7,
    input  logic [MQG_SEL_W-1:0]          i_report_channel,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [MQG_PORT_W-1:0]         o_motor_port,
    output logic [MQG_PORT_W-1:0]         o_image_port,
    output logic [MQG_PORT_W-1:0]         o_step_mask,
    output logic                          o_segment_done,
    output logic                          o_active,
    output logic signed [MQG_POS_W-1:0]   o_position,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [MQG_CFG_W-1:0]          i_cfg_data
);

    logic [MQG_CFG_W-1:0]  r_path_cycles;
    logic [CYCLE_BITS-1:0] r_cycle, n_cycle;
    logic                  r_seg_active, n_seg_active;

    logic                  w_accept;
    logic                  w_take;
    logic [CYCLE_BITS-1:0] w_period_raw;
    logic [CYCLE_BITS-1:0] w_period;
    logic [CYCLE_BITS-1:0] w_cyc_inc;
    logic                  w_done;
    t_lane_ctl             w_ctl;
    logic signed [MQG_COUNT_W-1:0] w_count [MQG_MAX_CH];
    t_lane_out             w_lane [MQG_MAX_CH];
    logic [MQG_POS_W-1:0]  w_position;

    assign o_stall     = o_valid && i_stall;
    assign w_accept    = i_valid && !o_stall;
    assign w_take      = o_valid && !i_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_cycles <= MQG_PATH_CYCLES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_path_cycles <= i_cfg_data;
        end
    end

    // period of zero acts as one
    always_comb begin
        w_period_raw = CYCLE_BITS'(r_path_cycles);
        w_period     = (w_period_raw == '0) ? CYCLE_BITS'(1) : w_period_raw;
    end

    always_comb begin
        w_cyc_inc    = r_cycle + CYCLE_BITS'(1);
        w_ctl.load   = w_accept && (i_opcode == MQG_OP_LOAD);
        w_ctl.tick   = w_accept && (i_opcode == MQG_OP_TICK) && r_seg_active;
        w_done       = w_ctl.tick && ((w_cyc_inc >= w_period) || (w_cyc_inc == '0));
        n_cycle      = r_cycle;
        n_seg_active = r_seg_active;
        if (w_ctl.load) begin
            n_cycle      = '0;
            n_seg_active = 1'b1;
        end else if (w_ctl.tick) begin
            n_cycle = w_cyc_inc;
            if (w_done) begin
                n_seg_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle      <= '0;
            r_seg_active <= 1'b0;
        end else begin
            r_cycle      <= n_cycle;
            r_seg_active <= n_seg_active;
        end
    end

    always_comb begin
        w_count[0] = i_count_0;
        w_count[1] = i_count_1;
        w_count[2] = i_count_2;
        w_count[3] = i_count_3;
        w_count[4] = i_count_4;
        w_count[5] = i_count_5;
        w_count[6] = i_count_6;
        w_count[7] = i_count_7;
    end

    for (genvar g = 0; g < MQG_MAX_CH; g++) begin : g_lane
        if (g < CHANNELS) begin : g_on
            mqg_lane #(
                .CYCLE_BITS (CYCLE_BITS)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_period (w_period),
                .i_count  (w_count[g]),
                .o_lane   (w_lane[g])
            );
        end else begin : g_off
            assign w_lane[g] = '0;
        end
    end

    mqg_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_accept),
        .i_take         (w_take),
        .i_lane         (w_lane),
        .i_sel          (i_report_channel),
        .i_done         (w_done),
        .i_active       (n_seg_active),
        .o_valid        (o_valid),
        .o_motor_port   (o_motor_port),
        .o_image_port   (o_image_port),
        .o_step_mask    (o_step_mask),
        .o_segment_done (o_segment_done),
        .o_active       (o_active),
        .o_position     (w_position)
    );

    assign o_position = $signed(w_position);

endmodule

[test/multi_axis_step_quadrature_generator_top_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for multi_axis_step_quadrature_generator_top: random request and result
// pacing, path_cycles rewrites between phases, and an exact per-request predictor of the step generator
// depends on mqg_pkg and the top level only
module multi_axis_step_quadrature_generator_top_tb;
    import mqg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 420;
    localparam int CYC_MASK       = (1 << MQG_CYCLE_BITS) - 1;

    // gray order 00,10,11,01 indexed by current code
    localparam logic [3:0][1:0] GRAY_FWD  = {2'd1, 2'd3, 2'd0, 2'd2};
    localparam logic [3:0][1:0] GRAY_BACK = {2'd2, 2'd0, 2'd3, 2'd1};

    typedef struct packed {
        logic                                  op;
        logic [MQG_CHANNELS-1:0][MQG_COUNT_W-1:0] counts;
        logic [MQG_SEL_W-1:0]                  sel;
    } t_request;

    typedef struct packed {
        logic [MQG_PORT_W-1:0]       motor;
        logic [MQG_PORT_W-1:0]       image;
        logic [MQG_PORT_W-1:0]       mask;
        logic                        done;
        logic                        active;
        logic signed [MQG_POS_W-1:0] position;
    } t_move;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic                          i_opcode = MQG_OP_TICK;
    logic signed [MQG_COUNT_W-1:0] i_count_0 = '0;
    logic signed [MQG_COUNT_W-1:0] i_count_1 = '0;
    logic signed [MQG_COUNT_W-1:0] i_count_2 = '0;
    logic signed [MQG_COUNT_W-1:0] i_count_3 = '0;
    logic signed [MQG_COUNT_W-1:0] i_count_4 = '0;
    logic signed [MQG_COUNT_W-1:0] i_count_5 = '0;
    logic signed [MQG_COUNT_W-1:0] i_count_6 = '0;
    logic signed [MQG_COUNT_W-1:0] i_count_7 = '0;
    logic [MQG_SEL_W-1:0]          i_report_channel = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [MQG_PORT_W-1:0]         o_motor_port;
    logic [MQG_PORT_W-1:0]         o_image_port;
    logic [MQG_PORT_W-1:0]         o_step_mask;
    logic                          o_segment_done;
    logic                          o_active;
    logic signed [MQG_POS_W-1:0]   o_position;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [MQG_CFG_W-1:0]          i_cfg_data = '0;

    multi_axis_step_quadrature_generator_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_count_0        (i_count_0),
        .i_count_1        (i_count_1),
        .i_count_2        (i_count_2),
        .i_count_3        (i_count_3),
        .i_count_4        (i_count_4),
        .i_count_5        (i_count_5),
        .i_count_6        (i_count_6),
        .i_count_7        (i_count_7),
        .i_report_channel (i_report_channel),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_motor_port     (o_motor_port),
        .o_image_port     (o_image_port),
        .o_step_mask      (o_step_mask),
        .o_segment_done   (o_segment_done),
        .o_active         (o_active),
        .o_position       (o_position),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_request request_queue[$];
    t_move    expected_moves[$];
    t_request held_req;
    t_move    next_move;
    t_move    want_move;
    int       send_wait = 0;
    bit       send_burst = 1'b0;
    int       stall_left = 0;
    bit       stall_burst = 1'b0;
    int       error_count = 0;
    int       idle_cycles = 0;
    int       random_items = 0;

    // predictor state
    logic [MQG_CFG_W-1:0] path_cycles_cfg = MQG_PATH_CYCLES_RST;
    int                   seg_cycle = 0;
    bit                   seg_live = 1'b0;
    int                   lane_mag [MQG_CHANNELS];
    bit                   lane_neg [MQG_CHANNELS];
    int                   lane_acc [MQG_CHANNELS];
    logic [1:0]           lane_quad [MQG_CHANNELS];
    logic [MQG_POS_W-1:0] lane_pos [MQG_CHANNELS];

    initial begin
        for (int ch = 0; ch < MQG_CHANNELS; ch++) begin
            lane_mag[ch]  = 0;
            lane_neg[ch]  = 1'b0;
            lane_acc[ch]  = 0;
            lane_quad[ch] = 2'd0;
            lane_pos[ch]  = '0;
        end
    end

    task automatic interpolate_request(input t_request req, output t_move res);
        int         p;
        int         n;
        int         a;
        int         c;
        logic [7:0] stepped;
        logic       finished;
        p = (path_cycles_cfg == '0) ? 1 : int'(path_cycles_cfg);
        stepped = '0;
        finished = 1'b0;
        if (req.op == MQG_OP_LOAD) begin
            for (int ch = 0; ch < MQG_CHANNELS; ch++) begin
                c = int'($signed(req.counts[ch]));
                n = (c < 0) ? -c : c;
                if (n > p) n = p;
                lane_mag[ch] = n;
                lane_neg[ch] = (c < 0) && (n != 0);
                // accumulator for the first cycle is (p-1)*n mod p
                lane_acc[ch] = (n == 0 || n == p) ? 0 : p - n;
            end
            seg_cycle = 0;
            seg_live = 1'b1;
        end else if (seg_live) begin
            seg_cycle = (seg_cycle + 1) & CYC_MASK;
            for (int ch = 0; ch < MQG_CHANNELS; ch++) begin
                n = lane_mag[ch];
                a = lane_acc[ch];
                if (n != 0 && a < n) begin
                    stepped[ch] = 1'b1;
                    if (lane_neg[ch]) begin
                        lane_quad[ch] = GRAY_BACK[lane_quad[ch]];
                        lane_pos[ch]  = lane_pos[ch] - 1;
                    end else begin
                        lane_quad[ch] = GRAY_FWD[lane_quad[ch]];
                        lane_pos[ch]  = lane_pos[ch] + 1;
                    end
                end
                a = (a >= n) ? a - n : a + p - n;
                lane_acc[ch] = a & CYC_MASK;
            end
            if (seg_cycle >= p || seg_cycle == 0) begin
                finished = 1'b1;
                seg_live = 1'b0;
            end
        end
        res.motor    = {lane_quad[0], lane_quad[1], lane_quad[2], lane_quad[3]};
        res.image    = {lane_quad[4], lane_quad[5], lane_quad[6], lane_quad[7]};
        res.mask     = stepped;
        res.done     = finished;
        res.active   = seg_live;
        res.position = lane_pos[req.sel];
    endtask

    // driver: holds the request until it is taken, then waits its drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                interpolate_request(held_req, next_move);
                expected_moves.push_back(next_move);
                if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
                send_wait = send_burst ? 0 : $urandom_range(0, 16);
            end
            if (!i_valid || !o_stall) begin
                if (send_wait > 0) begin
                    send_wait = send_wait - 1;
                    i_valid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    held_req = request_queue.pop_front();
                    i_opcode         <= held_req.op;
                    i_count_0        <= held_req.counts[0];
                    i_count_1        <= held_req.counts[1];
                    i_count_2        <= held_req.counts[2];
                    i_count_3        <= held_req.counts[3];
                    i_count_4        <= held_req.counts[4];
                    i_count_5        <= held_req.counts[5];
                    i_count_6        <= held_req.counts[6];
                    i_count_7        <= held_req.counts[7];
                    i_report_channel <= held_req.sel;
                    i_valid          <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random stall per result, field-by-field compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_moves.size() == 0) begin
                    $error("unexpected result: motor_port %h position %0d",
                           o_motor_port, o_position);
                    error_count++;
                end else begin
                    want_move = expected_moves.pop_front();
                    if (o_motor_port !== want_move.motor) begin
                        $error("motor_port expected %h got %h", want_move.motor, o_motor_port);
                        error_count++;
                    end
                    if (o_image_port !== want_move.image) begin
                        $error("image_port expected %h got %h", want_move.image, o_image_port);
                        error_count++;
                    end
                    if (o_step_mask !== want_move.mask) begin
                        $error("step_mask expected %h got %h", want_move.mask, o_step_mask);
                        error_count++;
                    end
                    if (o_segment_done !== want_move.done) begin
                        $error("segment_done expected %b got %b", want_move.done, o_segment_done);
                        error_count++;
                    end
                    if (o_active !== want_move.active) begin
                        $error("active expected %b got %b", want_move.active, o_active);
                        error_count++;
                    end
                    if (o_position !== want_move.position) begin
                        $error("position expected %0d got %0d", want_move.position, o_position);
                        error_count++;
                    end
                end
                if ($urandom_range(0, 15) == 0) stall_burst = ~stall_burst;
                stall_left = stall_burst ? 0 : $urandom_range(0, 16);
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
            end
            i_stall <= (stall_left != 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL multi_axis_step_quadrature_generator_top");
            $finish;
        end
    end

    task automatic queue_load(input int c0, input int c1, input int c2, input int c3,
                              input int c4, input int c5, input int c6, input int c7,
                              input int sel);
        t_request req;
        req.op        = MQG_OP_LOAD;
        req.counts[0] = c0[MQG_COUNT_W-1:0];
        req.counts[1] = c1[MQG_COUNT_W-1:0];
        req.counts[2] = c2[MQG_COUNT_W-1:0];
        req.counts[3] = c3[MQG_COUNT_W-1:0];
        req.counts[4] = c4[MQG_COUNT_W-1:0];
        req.counts[5] = c5[MQG_COUNT_W-1:0];
        req.counts[6] = c6[MQG_COUNT_W-1:0];
        req.counts[7] = c7[MQG_COUNT_W-1:0];
        req.sel       = sel[MQG_SEL_W-1:0];
        request_queue.push_back(req);
    endtask

    // tick payload counts are don't-care for the block, so they carry noise
    task automatic queue_ticks(input int count);
        t_request req;
        for (int k = 0; k < count; k++) begin
            req.op = MQG_OP_TICK;
            for (int ch = 0; ch < MQG_CHANNELS; ch++)
                req.counts[ch] = MQG_COUNT_W'($urandom_range(0, (1 << MQG_COUNT_W) - 1));
            req.sel = MQG_SEL_W'($urandom_range(0, MQG_CHANNELS - 1));
            request_queue.push_back(req);
        end
    endtask

    function automatic int pick_count(input int p);
        int m;
        m = $urandom_range(0, p);
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 4095;
            2:       return -4095;
            3:       return -4096;
            4, 5:    return int'($urandom_range(0, 8191)) - 4096;
            default: return $urandom_range(0, 1) ? m : -m;
        endcase
    endfunction

    task automatic queue_random_load(input int p);
        queue_load(pick_count(p), pick_count(p), pick_count(p), pick_count(p),
                   pick_count(p), pick_count(p), pick_count(p), pick_count(p),
                   $urandom_range(0, MQG_CHANNELS - 1));
    endtask

    // sampled at the falling edge so the clocked blocks have all settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (request_queue.size() != 0 || i_valid || expected_moves.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_path_cycles(input logic [MQG_CFG_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        path_cycles_cfg = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int p_raw;
        int p_eff;
        int n;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset period: tick while idle, then counts clamped to 400
        queue_ticks(1);
        queue_load(4095, -4096, 400, -1, 0, 200, -399, 1, 7);
        queue_ticks(2);
        write_path_cycles(12'd8);
        // full segment with zero, exact, clamped and odd counts, then idle tick
        queue_load(0, 8, -8, 4095, -4096, 3, -5, 1, 3);
        queue_ticks(9);
        queue_load(2, -2, 7, -7, 1, -1, 5, -3, 6);
        queue_ticks(3);
        // reload drops the running segment
        queue_load(-4095, 6, 7, -7, 4, 0, -1, 8, 2);
        queue_ticks(2);
        // shorter period mid-segment ends it on the next tick, counts keep magnitude
        write_path_cycles(12'd2);
        queue_ticks(1);
        // zero period acts as one
        write_path_cycles(12'd0);
        queue_load(1, -1, 0, 5, -5, 4095, -4096, 0, 5);
        queue_ticks(2);
        write_path_cycles(12'd1);
        queue_random_load(1);
        queue_ticks(2);

        // one complete segment at a long period, then an idle tick
        write_path_cycles(12'd300);
        queue_load(4095, -4096, 1, -1, 150, -149, 299, -3, 0);
        queue_ticks(301);

        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       p_raw = 0;
                1:       p_raw = 1;
                2:       p_raw = 2;
                3, 4, 5: p_raw = $urandom_range(3, 40);
                6, 7:    p_raw = $urandom_range(41, 130);
                8:       p_raw = $urandom_range(131, 400);
                default: p_raw = $urandom_range(401, 4095);
            endcase
            p_eff = (p_raw == 0) ? 1 : p_raw;
            write_path_cycles(p_raw[MQG_CFG_W-1:0]);
            // a segment left running from the last phase continues under the new period
            if ($urandom_range(0, 1)) queue_ticks($urandom_range(1, 4));
            repeat ($urandom_range(2, 5)) begin
                queue_random_load(p_eff);
                n = ($urandom_range(0, 4) != 0) ? p_eff + $urandom_range(0, 2)
                                                : $urandom_range(0, p_eff);
                if (n > 150) n = $urandom_range(20, 150);
                queue_ticks(n);
                random_items = random_items + 1 + n;
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (expected_moves.size() != 0) begin
            $error("%0d results never arrived", expected_moves.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASS multi_axis_step_quadrature_generator_top");
        else
            $display("FAIL multi_axis_step_quadrature_generator_top");
        $finish;
    end

endmodule

[sim.f]
rtl/mqg_pkg.sv
rtl/mqg_lane.sv
rtl/mqg_merge.sv
rtl/multi_axis_step_quadrature_generator_top.sv
test/multi_axis_step_quadrature_generator_top_tb.sv
